### hw/rtl/arlc_pkg.sv
`timescale 1ns / 1ps

package arlc_pkg;

    // Widths of the beat fields; fixed by the stream format.
    localparam int ADDR_W  = 64;
    localparam int PERM_W  = 4;
    localparam int INDEX_W = 8;

    // Item kinds carried on the input tuser bit.
    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_APPEND = 1'b1;

    // Lookup token handed from cell to cell along the chain.
    typedef struct packed {
        logic               valid;
        logic               hit;
        logic [INDEX_W-1:0] idx;
        logic [ADDR_W-1:0]  mapped;
        logic [PERM_W-1:0]  perms;
        logic [ADDR_W-1:0]  addr;
    } tok_t;

    // Region write broadcast to all cells; delta is file offset minus start.
    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  start;
        logic [ADDR_W-1:0]  stop;
        logic [ADDR_W-1:0]  delta;
        logic [PERM_W-1:0]  perms;
    } wr_t;

endpackage

### hw/rtl/arlc_cell.sv
`timescale 1ns / 1ps

module arlc_cell #(
    parameter int CELL_IDX = 0,
    parameter int CNT_W    = 9
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  logic [CNT_W-1:0]     count,
    input  arlc_pkg::wr_t        wr,
    input  arlc_pkg::tok_t       tok_in,
    output arlc_pkg::tok_t       tok_out
);
    import arlc_pkg::*;

    logic [ADDR_W-1:0] start_reg;
    logic [ADDR_W-1:0] stop_reg;
    logic [ADDR_W-1:0] delta_reg;
    logic [PERM_W-1:0] perm_reg;
    tok_t              tok_reg;
    tok_t              tok_next;
    logic              active;
    logic              match;

    // This cell holds a region once the fill count has passed its slot.
    assign active = (count > CNT_W'(CELL_IDX));

    // Region store: loaded when the append lands on this slot.
    always_ff @(posedge aclk) begin
        if (wr.en && (count == CNT_W'(CELL_IDX))) begin
            start_reg <= wr.start;
            stop_reg  <= wr.stop;
            delta_reg <= wr.delta;
            perm_reg  <= wr.perms;
        end
    end

    // The first containing region along the chain claims the token.
    assign match = tok_in.valid && !tok_in.hit && active
                   && (start_reg <= tok_in.addr) && (tok_in.addr < stop_reg);

    always_comb begin
        tok_next = tok_in;
        if (match) begin
            tok_next.hit    = 1'b1;
            tok_next.idx    = INDEX_W'(CELL_IDX);
            tok_next.mapped = tok_in.addr + delta_reg;
            tok_next.perms  = perm_reg;
        end
    end

    // Token stage towards the next cell.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else if (adv) begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

### hw/rtl/address_range_region_lookup_core.sv
`timescale 1ns / 1ps

// Channel   Direction  tdata fields (lowest bit up)                          tuser
// s_        in         address, region_start, region_end, file_offset,       action
//                      perm_bits, zero pad to 264 bits
// m_        out        hit, entry_index, mapped_offset, hit_perms,           -
//                      table_full, zero pad to 80 bits
//
// One item is in flight at a time. A lookup walks the row of CAPACITY cells,
// one cell per cycle, and then enters the output register; an append into a
// table with room writes its slot when the beat is taken, and its result waits
// in a pending register. A new input beat is taken as soon as the previous
// result has reached the output register, even while that result waits for m_tready.
// Reset clears the fill count and all handshake state; stored regions are not
// cleared. A stalled output holds the finished token at the end of the row.

module address_range_region_lookup_core #(
    parameter int CAPACITY = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [263:0] s_tdata,  // address, region_start, region_end, file_offset, perm_bits
    input  logic         s_tuser,  // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata   // hit, entry_index, mapped_offset, hit_perms, table_full
);
    import arlc_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic               busy_reg;
    logic               busy_next;
    logic [CNT_W-1:0]   entry_count_reg;
    logic [CNT_W-1:0]   entry_count_next;
    logic               pend_valid_reg;
    logic               pend_valid_next;
    logic [INDEX_W-1:0] pend_idx_reg;
    logic               pend_full_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_hit_reg;
    logic [INDEX_W-1:0] out_idx_reg;
    logic [ADDR_W-1:0]  out_mapped_reg;
    logic [PERM_W-1:0]  out_perms_reg;
    logic               out_full_reg;

    logic               in_beat;
    logic               append_beat;
    logic               lookup_beat;
    logic               table_is_full;
    logic               load_out;
    logic               adv;
    logic [ADDR_W-1:0]  in_addr;
    logic [ADDR_W-1:0]  in_start;
    logic [ADDR_W-1:0]  in_stop;
    logic [ADDR_W-1:0]  in_offset;
    logic [PERM_W-1:0]  in_perms;
    wr_t                wr;
    tok_t               chain [0:CAPACITY];
    tok_t               last_tok;

    // Input beat unpacking.
    assign in_addr   = s_tdata[63:0];
    assign in_start  = s_tdata[127:64];
    assign in_stop   = s_tdata[191:128];
    assign in_offset = s_tdata[255:192];
    assign in_perms  = s_tdata[259:256];

    assign s_tready      = !busy_reg;
    assign in_beat       = s_tvalid && s_tready;
    assign append_beat   = in_beat && (s_tuser == ACT_APPEND);
    assign lookup_beat   = in_beat && (s_tuser == ACT_LOOKUP);
    assign table_is_full = (entry_count_reg >= CNT_W'(CAPACITY));

    // Region write towards the slot given by the fill count.
    assign wr.en    = append_beat && !table_is_full;
    assign wr.start = in_start;
    assign wr.stop  = in_stop;
    assign wr.delta = in_offset - in_start;
    assign wr.perms = in_perms;

    // Fresh lookup token entering the first cell.
    always_comb begin
        chain[0].valid  = lookup_beat;
        chain[0].hit    = 1'b0;
        chain[0].idx    = '0;
        chain[0].mapped = '0;
        chain[0].perms  = '0;
        chain[0].addr   = in_addr;
    end

    // Row of cells, one region each.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        arlc_cell #(
            .CELL_IDX (i),
            .CNT_W    (CNT_W)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .count   (entry_count_reg),
            .wr      (wr),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    assign last_tok = chain[CAPACITY];

    // The output register takes whichever result is ready when it is free.
    assign load_out = (pend_valid_reg || last_tok.valid) && (!out_valid_reg || m_tready);
    assign adv      = !(last_tok.valid && !load_out);

    // Control next-state logic.
    always_comb begin
        entry_count_next = entry_count_reg;
        pend_valid_next  = pend_valid_reg;
        busy_next        = busy_reg;
        out_valid_next   = out_valid_reg;
        if (wr.en) begin
            entry_count_next = entry_count_reg + CNT_W'(1);
        end
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (load_out) begin
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
            busy_next       = 1'b0;
        end
        if (in_beat) begin
            busy_next = 1'b1;
        end
        if (append_beat) begin
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
            pend_valid_reg  <= 1'b0;
            busy_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            entry_count_reg <= entry_count_next;
            pend_valid_reg  <= pend_valid_next;
            busy_reg        <= busy_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Append result waiting for the output register.
    always_ff @(posedge aclk) begin
        if (append_beat) begin
            pend_idx_reg  <= table_is_full ? '0 : INDEX_W'(entry_count_reg);
            pend_full_reg <= table_is_full;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (load_out) begin
            if (pend_valid_reg) begin
                out_hit_reg    <= 1'b0;
                out_idx_reg    <= pend_idx_reg;
                out_mapped_reg <= '0;
                out_perms_reg  <= '0;
                out_full_reg   <= pend_full_reg;
            end else begin
                out_hit_reg    <= last_tok.hit;
                out_idx_reg    <= last_tok.idx;
                out_mapped_reg <= last_tok.mapped;
                out_perms_reg  <= last_tok.perms;
                out_full_reg   <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_full_reg, out_perms_reg, out_mapped_reg,
                       out_idx_reg, out_hit_reg};

    // An append result and a lookup token never wait at the same time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(pend_valid_reg && last_tok.valid))
        else $error("append result and lookup token both pending");

    // Ready for a beat means no append result is pending and no token waits at the end of the row.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (!pend_valid_reg && !last_tok.valid))
        else $error("input ready while an item is still in flight");

    // The fill count never passes the table size.
    assert property (@(posedge aclk) disable iff (!aresetn)
        entry_count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // An accepted append into a table with room advances the fill count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (append_beat && !table_is_full) |=>
            (entry_count_reg == $past(entry_count_reg) + CNT_W'(1)))
        else $error("append did not advance entry count");

    // A waiting token at the end of the row is held while the output stalls.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (last_tok.valid && !load_out) |=> (last_tok.valid && $stable(last_tok.addr)))
        else $error("stalled lookup token lost");

endmodule
